/* rtl/sv39_ptw_pkg.sv */
// ----------------------------------------------------------------------------
// sv39_ptw_pkg
// Shared constants, codes and types of the Sv39 page-table walker.
// ----------------------------------------------------------------------------
package sv39_ptw_pkg;

	localparam int TABLE_PAGES       = 64;
	localparam int ENTRIES_PER_TABLE = 512;
	localparam int SLICE_W           = $clog2(ENTRIES_PER_TABLE);
	localparam int TBL_W             = $clog2(TABLE_PAGES);
	localparam int NFT_W             = $clog2(TABLE_PAGES + 1);
	localparam int STORE_DEPTH       = TABLE_PAGES * ENTRIES_PER_TABLE;
	localparam int ADDR_W            = $clog2(STORE_DEPTH);

	localparam int VA_W    = 39;
	localparam int PA_W    = 56;
	localparam int PERM_W  = 10;
	localparam int PPN_W   = 44;
	localparam int ENTRY_W = 64;
	localparam int OFFS_W  = 12;

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_MAP    = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_VA     = 3'd1,
		ST_NOT_MAPPED = 3'd2,
		ST_MISALIGNED = 3'd3,
		ST_NO_SPACE   = 3'd4,
		ST_ALREADY    = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EVAL,
		S_SWEEP,
		S_LINK,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t               op;
		logic [VA_W-1:0]   va;
		logic [PA_W-1:0]   pa;
		logic [PERM_W-1:0] perm;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [ENTRY_W-1:0] entry;
	} res_t;

	typedef struct packed {
		logic               we;
		logic               re;
		logic [ADDR_W-1:0]  addr;
		logic [ENTRY_W-1:0] wdata;
	} mem_req_t;

	// 9-bit VPN field of the given level
	function automatic logic [SLICE_W-1:0] vpn_slice(input logic [VA_W-1:0] va,
			input logic [1:0] level);
		logic [SLICE_W-1:0] s;
		case (level)
			2'd2: begin
				s = va[OFFS_W+2*SLICE_W +: SLICE_W];
			end
			2'd1: begin
				s = va[OFFS_W+SLICE_W +: SLICE_W];
			end
			default: begin
				s = va[OFFS_W +: SLICE_W];
			end
		endcase
		return s;
	endfunction

endpackage

/* rtl/sv39_ptw_ram.sv */
// ----------------------------------------------------------------------------
// sv39_ptw_ram
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module sv39_ptw_ram #(
	parameter int DATA_W = 64,
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [ADDR_W-1:0] addr,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

/* rtl/sv39_ptw_walk.sv */
// ----------------------------------------------------------------------------
// sv39_ptw_walk
// Walk sequencer: reset clear, three-level walk, table allocation and leaf write.
// ----------------------------------------------------------------------------
module sv39_ptw_walk
	import sv39_ptw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [PPN_W-1:0]   base_ppn,
	input  logic               in_valid,
	output logic               in_ready,
	input  req_t               in_item,
	output logic               res_valid,
	input  logic               res_ready,
	output res_t               res,
	output mem_req_t           mem_req,
	input  logic [ENTRY_W-1:0] mem_rdata
);

	localparam logic [PPN_W-1:0]  PAGES_PPN  = PPN_W'(TABLE_PAGES);
	localparam logic [NFT_W-1:0]  PAGES_NFT  = NFT_W'(TABLE_PAGES);
	localparam logic [ADDR_W-1:0] CLEAR_LAST = ADDR_W'(STORE_DEPTH - 1);

	state_t             state_q, state_d;
	logic [1:0]         level_q, level_d;
	logic [TBL_W-1:0]   tbl_q, tbl_d;
	logic [NFT_W-1:0]   nft_q, nft_d;
	logic [ADDR_W-1:0]  cnt_q, cnt_d;
	req_t               req_q, req_d;
	status_t            status_q, status_d;
	logic [ENTRY_W-1:0] entry_q, entry_d;

	logic [PPN_W-1:0]   k_ppn;
	logic               foreign;
	logic               va_high;
	logic               misaligned;
	logic [ADDR_W-1:0]  walk_addr;

	assign k_ppn      = mem_rdata[PPN_W+PERM_W-1:PERM_W] - base_ppn;
	assign foreign    = k_ppn >= PAGES_PPN;
	assign va_high    = in_item.va[VA_W-1];
	assign misaligned = (|in_item.va[OFFS_W-1:0]) || (|in_item.pa[OFFS_W-1:0]);
	assign walk_addr  = {tbl_q, vpn_slice(req_q.va, level_q)};

	assign in_ready   = (state_q == S_IDLE);
	assign res_valid  = (state_q == S_DONE);
	assign res.status = status_q;
	assign res.entry  = entry_q;

	always_comb begin
		state_d  = state_q;
		level_d  = level_q;
		tbl_d    = tbl_q;
		nft_d    = nft_q;
		cnt_d    = cnt_q;
		req_d    = req_q;
		status_d = status_q;
		entry_d  = entry_q;
		mem_req  = '0;
		case (state_q)
			S_CLEAR: begin
				mem_req.we   = 1'b1;
				mem_req.addr = cnt_q;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CLEAR_LAST) begin
					cnt_d   = '0;
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					req_d   = in_item;
					level_d = 2'd2;
					tbl_d   = '0;
					entry_d = '0;
					state_d = S_READ;
					if (in_item.op == OP_MAP && misaligned) begin
						status_d = ST_MISALIGNED;
						state_d  = S_DONE;
					end else if (va_high) begin
						status_d = ST_BAD_VA;
						state_d  = S_DONE;
					end
				end
			end
			S_READ: begin
				mem_req.re   = 1'b1;
				mem_req.addr = walk_addr;
				state_d      = S_EVAL;
			end
			S_EVAL: begin
				state_d = S_DONE;
				if (level_q != 2'd0) begin
					if (mem_rdata[0]) begin
						if (foreign) begin
							status_d = (req_q.op == OP_MAP) ? ST_NO_SPACE : ST_NOT_MAPPED;
						end else begin
							tbl_d   = k_ppn[TBL_W-1:0];
							level_d = level_q - 1'b1;
							state_d = S_READ;
						end
					end else if (req_q.op == OP_LOOKUP) begin
						status_d = ST_NOT_MAPPED;
					end else if (nft_q >= PAGES_NFT) begin
						status_d = ST_NO_SPACE;
					end else begin
						cnt_d   = '0;
						state_d = S_SWEEP;
					end
				end else if (mem_rdata[0]) begin
					// valid leaf: report it, map leaves the store alone
					status_d = (req_q.op == OP_MAP) ? ST_ALREADY : ST_OK;
					entry_d  = mem_rdata;
				end else if (req_q.op == OP_LOOKUP) begin
					status_d = ST_NOT_MAPPED;
				end else begin
					mem_req.we    = 1'b1;
					mem_req.addr  = walk_addr;
					mem_req.wdata = {{(ENTRY_W-PPN_W-PERM_W){1'b0}},
						req_q.pa[PA_W-1:OFFS_W], req_q.perm | PERM_W'(1)};
					entry_d       = mem_req.wdata;
					status_d      = ST_OK;
				end
			end
			S_SWEEP: begin
				// zero the new table before it is linked in
				mem_req.we   = 1'b1;
				mem_req.addr = {nft_q[TBL_W-1:0], cnt_q[SLICE_W-1:0]};
				cnt_d        = cnt_q + 1'b1;
				if (&cnt_q[SLICE_W-1:0]) begin
					state_d = S_LINK;
				end
			end
			S_LINK: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = walk_addr;
				mem_req.wdata = {{(ENTRY_W-PPN_W-PERM_W){1'b0}},
					base_ppn + PPN_W'(nft_q), PERM_W'(1)};
				tbl_d         = nft_q[TBL_W-1:0];
				nft_d         = nft_q + 1'b1;
				level_d       = level_q - 1'b1;
				state_d       = S_READ;
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			nft_q   <= NFT_W'(1);
			cnt_q   <= '0;
			level_q <= '0;
			tbl_q   <= '0;
		end else begin
			state_q <= state_d;
			nft_q   <= nft_d;
			cnt_q   <= cnt_d;
			level_q <= level_d;
			tbl_q   <= tbl_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q    <= req_d;
		status_q <= status_d;
		entry_q  <= entry_d;
	end

endmodule

/* rtl/sv39_page_table_walker.sv */
// ----------------------------------------------------------------------------
// sv39_page_table_walker
// Sv39 three-level page-table walker with a private table store.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream takes one item per request: tuser is the op (lookup or
//    map), tdata carries va, pa and permission bits. Master stream returns
//    one item per request: tuser is the status, tdata the leaf entry and
//    the page address it names.
//  - cfg_we/cfg_wdata load table_base_ppn; write it only while idle.
//  - The store is one single-port RAM of TABLE_PAGES x 512 entries. Each
//    level of a walk is a table read followed by a check of the entry it
//    returns; an early error (bad va, misaligned) skips the walk. The leaf
//    write of a map shares the cycle of the leaf check. Each table a map
//    allocates adds a zero sweep of its entries plus a link.
//  - One item is in the walker at a time; the next is taken once the
//    previous result has moved into the output register.
//  - After reset all TABLE_PAGES*512 RAM entries (32768 as built) are
//    zeroed, with s_axis_tready low; cfg writes are taken during the clear.
//  - When m_axis_tready is low the result holds in the output register;
//    the walker still takes and walks the next item, then waits.
// ----------------------------------------------------------------------------
module sv39_page_table_walker
	import sv39_ptw_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [43:0]  cfg_wdata,     // table_base_ppn
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [111:0] s_axis_tdata,  // virt_addr[38:0], phys_addr[94:39],
	                                    // perm_bits[104:95], zero pad
	input  logic [0:0]   s_axis_tuser,  // op
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [119:0] m_axis_tdata,  // leaf_entry[63:0], leaf_phys[119:64]
	output logic [2:0]   m_axis_tuser   // status
);

	logic [PPN_W-1:0]   base_q;
	req_t               in_item;
	logic               res_valid;
	logic               res_ready;
	res_t               res;
	mem_req_t           mem_req;
	logic [ENTRY_W-1:0] mem_rdata;

	logic               out_valid_q;
	status_t            out_status_q;
	logic [ENTRY_W-1:0] out_entry_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_we) begin
			base_q <= cfg_wdata;
		end
	end

	// unpack the request item
	assign in_item.op   = op_t'(s_axis_tuser[0]);
	assign in_item.va   = s_axis_tdata[VA_W-1:0];
	assign in_item.pa   = s_axis_tdata[VA_W +: PA_W];
	assign in_item.perm = s_axis_tdata[VA_W+PA_W +: PERM_W];

	sv39_ptw_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.base_ppn  (base_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_item   (in_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	sv39_ptw_ram #(
		.DATA_W (ENTRY_W),
		.DEPTH  (STORE_DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (mem_req.we),
		.re    (mem_req.re),
		.addr  (mem_req.addr),
		.wdata (mem_req.wdata),
		.rdata (mem_rdata)
	);

	// output register: decouples the walker from a stalled receiver
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_status_q <= res.status;
			out_entry_q  <= res.entry;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	// leaf entry 0 gives page address 0, so no extra select is needed
	assign m_axis_tdata  = {out_entry_q[PPN_W+PERM_W-1:PERM_W], {OFFS_W{1'b0}}, out_entry_q};

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------
	a_mem_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.we && mem_req.re))
		else $error("store read and written in the same cycle");

	a_no_write_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !mem_req.we)
		else $error("store written right after an item was accepted");

	a_one_item_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("second item accepted while a walk is running");

	a_handoff_free: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result moved into a full output register");

endmodule
